>>> design/tvdsp_pkg.sv
// tvdsp_pkg: shared constants, types and codes of the two-voice drum sample player
// no dependencies; imported by every module of the block
`default_nettype none

package tvdsp_pkg;

    // sample store geometry
    localparam int NUM_SLOTS  = 7;
    localparam int SLOT_DEPTH = 32768;
    localparam int MEM_DEPTH  = NUM_SLOTS * SLOT_DEPTH;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int STEP_W     = $clog2(SLOT_DEPTH + 1);
    localparam int LEN_W      = STEP_W;

    // slot code carried per voice, all ones means no slot
    localparam logic [2:0] NO_SLOT = 3'd7;

    // configuration registers
    localparam int NUM_CENTERS = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER6   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd7;
    localparam logic signed [14:0] CENTER_RESET [NUM_CENTERS] =
        '{15'sd80, 15'sd170, 15'sd250, 15'sd330, 15'sd420, 15'sd500, 15'sd580};
    localparam logic [9:0] TOL_RESET = 10'd20;

    // input command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_LENGTH = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_WRITE,
        OP_LENGTH
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [1:0][2:0]       voice_slot;
        logic [2:0]            load_slot;
        logic [14:0]           load_addr;
        logic [15:0]           load_data;
        logic [LEN_W-1:0]      length;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

>>> design/tvdsp_in_if.sv
// tvdsp_in_if: input channel of the drum sample player, valid/ready plus command fields
// no dependencies
`default_nettype none

interface tvdsp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [14:0] note1_mv;
    logic signed [14:0] note2_mv;
    logic [2:0]         load_slot;
    logic [14:0]        load_addr;
    logic signed [15:0] load_data;
    logic [15:0]        slot_length;

    modport source (
        output valid, command, note1_mv, note2_mv, load_slot, load_addr, load_data,
               slot_length,
        input  ready
    );
    modport sink (
        input  valid, command, note1_mv, note2_mv, load_slot, load_addr, load_data,
               slot_length,
        output ready
    );
endinterface

`default_nettype wire

>>> design/tvdsp_out_if.sv
// tvdsp_out_if: result channel of the drum sample player, valid/ready plus two audio words
// no dependencies
`default_nettype none

interface tvdsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] audio1;
    logic signed [15:0] audio2;

    modport source (
        output valid, audio1, audio2,
        input  ready
    );
    modport sink (
        input  valid, audio1, audio2,
        output ready
    );
endinterface

`default_nettype wire

>>> design/two_voice_drum_sample_player.sv
// two-voice one-shot drum sample player; a tick transfer goes into the queue register, then
// into the output register, where its result waits to be taken; throughput one item per
// cycle while the output is not stalled, set by the single write / dual read sample memory
// and the output register; load commands give no result; the queue of four entries absorbs
// output stalls; synchronous active-low reset clears voice state, slot lengths and config;
// the sample memory is not cleared and holds garbage until written
`default_nettype none

module two_voice_drum_sample_player
    import tvdsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port, index 0..6 centers, 7 tolerance
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // command items in, audio frames out
    tvdsp_in_if.sink                   i_in,
    tvdsp_out_if.source                o_out
);

    // classified item from the front, queue head and status toward the back
    t_push   push;
    t_entry  head;
    t_q_stat q_stat;
    logic    pop;

    // front: window match for both voices, command filtering, config registers
    // bad slots, bad addresses and the unused command are dropped here
    tvdsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push)
    );

    // queue: decouples acceptance from the output side
    tvdsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // back: voice stepping, length table, sample memory reads and writes
    // loads drain even while a result waits; ticks wait for the output register
    tvdsp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

>>> design/tvdsp_front.sv
// tvdsp_front: config registers, window match per voice, command filtering
// depends on tvdsp_pkg and tvdsp_in_if
`default_nettype none

module tvdsp_front
    import tvdsp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tvdsp_in_if.sink                   i_in,
    input  wire t_q_stat               i_q_stat,
    output t_push                      o_push
);

    logic signed [14:0] r_center [NUM_CENTERS];
    logic [9:0]         r_tol;

    logic       accept;
    logic       keep;
    logic       slot_ok;
    logic       addr_ok;
    t_entry     entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CENTERS; i++) begin
                r_center[i] <= CENTER_RESET[i];
            end
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index inside {[REG_CENTER0:REG_CENTER6]}) begin
                r_center[i_cfg_index] <= i_cfg_data;
            end else if (i_cfg_index == REG_TOLERANCE) begin
                r_tol <= i_cfg_data[9:0];
            end
        end
    end

    // lowest matching slot wins, so scan from the top down
    function automatic logic [2:0] match_slot(input logic signed [14:0] mv);
        logic signed [16:0] v;
        logic signed [16:0] tol;
        logic signed [16:0] lo;
        logic signed [16:0] hi;
        logic [2:0]         res;
        v   = 17'(mv);
        tol = $signed({7'b0, r_tol});
        res = NO_SLOT;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            lo = 17'(r_center[i]) - tol;
            hi = 17'(r_center[i]) + tol;
            if (lo <= v && v <= hi) begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        slot_ok = 32'(i_in.load_slot) < NUM_SLOTS;
        addr_ok = 32'(i_in.load_addr) < SLOT_DEPTH;

        entry.voice_slot[0] = match_slot(i_in.note1_mv);
        entry.voice_slot[1] = match_slot(i_in.note2_mv);
        entry.load_slot     = i_in.load_slot;
        entry.load_addr     = i_in.load_addr;
        entry.load_data     = i_in.load_data;
        // lengths beyond the slot are clamped to the slot depth
        if (32'(i_in.slot_length) > SLOT_DEPTH) begin
            entry.length = LEN_W'(SLOT_DEPTH);
        end else begin
            entry.length = LEN_W'(i_in.slot_length);
        end

        case (i_in.command)
            CMD_TICK: begin
                entry.op = OP_TICK;
                keep     = 1'b1;
            end
            CMD_WRITE: begin
                entry.op = OP_WRITE;
                keep     = slot_ok && addr_ok;
            end
            CMD_LENGTH: begin
                entry.op = OP_LENGTH;
                keep     = slot_ok;
            end
            default: begin
                entry.op = OP_TICK;
                keep     = 1'b0;
            end
        endcase

        o_push.valid = accept && keep;
        o_push.entry = entry;
    end

endmodule

`default_nettype wire

>>> design/tvdsp_queue.sv
// tvdsp_queue: short register queue of classified items between front and back
// depends on tvdsp_pkg
`default_nettype none

module tvdsp_queue
    import tvdsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    input  wire logic    i_pop,
    output t_entry       o_head,
    output t_q_stat      o_stat
);

    t_entry             r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push.valid && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push.entry;
        end
    end

    assign o_head       = r_slots[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> design/tvdsp_back.sv
// tvdsp_back: voice state, slot lengths, sample memory and output register
// depends on tvdsp_pkg and tvdsp_out_if
`default_nettype none

module tvdsp_back
    import tvdsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_entry  i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    tvdsp_out_if.source  o_out
);

    logic [15:0]        r_mem [MEM_DEPTH];
    logic [15:0]        r_rd [2];
    logic               r_play [2];
    logic               r_out_valid;
    logic [STEP_W-1:0]  r_step [2];
    logic [2:0]         r_last [2];
    logic [LEN_W-1:0]   r_len [NUM_SLOTS];

    logic               head_tick;
    logic               tick_go;
    logic               wr_en;
    logic               len_en;
    logic [MEM_AW-1:0]  wr_addr;
    logic [MEM_AW-1:0]  rd_addr [2];
    logic               play [2];
    logic               hit [2];
    logic [LEN_W-1:0]   len_sel [2];
    logic [STEP_W-1:0]  step_eff [2];
    logic [STEP_W-1:0]  n_step [2];

    always_comb begin
        head_tick = (i_head.op == OP_TICK);
        o_pop     = !i_q_stat.empty && (!head_tick || !r_out_valid || o_out.ready);
        tick_go   = o_pop && head_tick;
        wr_en     = o_pop && (i_head.op == OP_WRITE);
        len_en    = o_pop && (i_head.op == OP_LENGTH);
        wr_addr   = MEM_AW'(32'(i_head.load_slot) * SLOT_DEPTH + 32'(i_head.load_addr));

        for (int v = 0; v < 2; v++) begin
            hit[v]      = (i_head.voice_slot[v] != NO_SLOT);
            len_sel[v]  = hit[v] ? r_len[i_head.voice_slot[v][SLOT_IDX_W-1:0]] : '0;
            // a new slot restarts the one-shot
            step_eff[v] = (r_last[v] != i_head.voice_slot[v]) ? '0 : r_step[v];
            play[v]     = hit[v] && (step_eff[v] < len_sel[v]);
            rd_addr[v]  = MEM_AW'(32'(i_head.voice_slot[v]) * SLOT_DEPTH + 32'(step_eff[v]));
            if (!hit[v]) begin
                n_step[v] = '0;
            end else if (play[v]) begin
                n_step[v] = step_eff[v] + 1'b1;
            end else begin
                n_step[v] = step_eff[v];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int v = 0; v < 2; v++) begin
                r_step[v] <= '0;
                r_last[v] <= NO_SLOT;
            end
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_len[s] <= '0;
            end
        end else begin
            if (tick_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (tick_go) begin
                for (int v = 0; v < 2; v++) begin
                    r_step[v] <= n_step[v];
                    r_last[v] <= i_head.voice_slot[v];
                end
            end
            if (len_en) begin
                r_len[i_head.load_slot[SLOT_IDX_W-1:0]] <= i_head.length;
            end
        end
    end

    // sample store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_head.load_data;
        end
        if (tick_go) begin
            r_rd[0] <= r_mem[rd_addr[0]];
            r_rd[1] <= r_mem[rd_addr[1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_play[0] <= play[0];
            r_play[1] <= play[1];
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.audio1 = r_play[0] ? r_rd[0] : '0;
    assign o_out.audio2 = r_play[1] ? r_rd[1] : '0;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step[0] <= STEP_W'(SLOT_DEPTH) && r_step[1] <= STEP_W'(SLOT_DEPTH))
        else $error("voice step beyond slot depth");

    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_go |=> r_out_valid)
        else $error("tick did not produce a result");

    a_silent_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_go && i_head.voice_slot[0] == NO_SLOT)
            |=> (r_step[0] == '0 && r_last[0] == NO_SLOT && !r_play[0]))
        else $error("unmatched voice not cleared");

endmodule

`default_nettype wire

>>> test/two_voice_drum_sample_player_tb.sv
// two_voice_drum_sample_player_tb: self-checking bench for the two-voice drum sample player
// drives command transfers and random config phases, checks every audio frame against its own
// predictor; depends on tvdsp_pkg, tvdsp_in_if, tvdsp_out_if and the player itself
`default_nettype none

module two_voice_drum_sample_player_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvdsp_pkg::*;

    // command code the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int ITEMS_PER_PHASE = 390;
    localparam int IDLE_LIMIT      = 2000;   // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES   = 12;     // pipeline plus queue, with margin
    localparam int NOTE_MIN        = -10000;
    localparam int NOTE_MAX        = 10000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [14:0] note1;
        logic signed [14:0] note2;
        logic [2:0]         slot;
        logic [14:0]        addr;
        logic signed [15:0] data;
        logic [15:0]        length;
    } cmd_item_t;

    typedef struct packed {
        logic signed [15:0] audio1;
        logic signed [15:0] audio2;
    } frame_t;

    typedef struct packed {
        logic [15:0] step;
        logic [2:0]  last;
    } voice_t;

    typedef logic signed [14:0] center_set_t [NUM_SLOTS];

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tvdsp_in_if  in_if ();
    tvdsp_out_if out_if ();

    two_voice_drum_sample_player dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // commands waiting to be driven, frames waiting to come out
    cmd_item_t pending_cmds [$];
    frame_t    expected_frames [$];

    // window settings, only changed while the block is idle
    center_set_t centers;
    logic [9:0]  tolerance;

    // state as the block should hold it, advanced on each accepted transfer
    logic [15:0] slot_len [NUM_SLOTS];
    voice_t      voices [2];
    logic [15:0] sample_words [MEM_DEPTH];

    // state as the stimulus planner sees it, runs ahead of the transfers
    logic [15:0] plan_len [NUM_SLOTS];
    voice_t      plan_voices [2];
    bit          word_written [MEM_DEPTH];
    int          written_prefix [NUM_SLOTS];
    int          aim [2];

    int planned_count;
    int accepted_count;
    int mismatches;

    // driver and receiver private state
    cmd_item_t in_flight;
    int        send_gap;
    int        hold_off;
    bit        calm_send;
    bit        calm_recv;
    int        idle_cycles;

    function automatic int word_index(input logic [2:0] s, input logic [15:0] a);
        return int'(s) * SLOT_DEPTH + int'(a);
    endfunction

    function automatic logic [15:0] clamp_length(input logic [15:0] len);
        return (len > SLOT_DEPTH) ? 16'(SLOT_DEPTH) : len;
    endfunction

    // lowest slot whose inclusive window holds the voltage
    function automatic logic [2:0] match_slot(input int mv);
        int c;
        int t;
        t = int'(tolerance);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            c = int'(centers[i]);
            if (c - t <= mv && mv <= c + t) return 3'(i);
        end
        return NO_SLOT;
    endfunction

    // one voice for one tick: returns 1 when a word is read at rd_step
    function automatic logic step_voice(inout voice_t v, input logic [2:0] slot,
                                        input logic [15:0] len, output logic [15:0] rd_step);
        rd_step = '0;
        if (slot == NO_SLOT) begin
            v.step = '0;
            v.last = NO_SLOT;
            return 1'b0;
        end
        if (v.last != slot) begin
            v.last = slot;
            v.step = '0;
        end
        rd_step = v.step;
        if (v.step >= len) return 1'b0;
        v.step = v.step + 16'd1;
        return 1'b1;
    endfunction

    // expected effect of one accepted command
    function automatic void play_command(input cmd_item_t it);
        logic [2:0]  s1;
        logic [2:0]  s2;
        logic [15:0] st;
        frame_t      f;
        case (it.command)
            CMD_TICK: begin
                s1 = match_slot(it.note1);
                s2 = match_slot(it.note2);
                f.audio1 = '0;
                f.audio2 = '0;
                if (step_voice(voices[0], s1, slot_len[s1], st))
                    f.audio1 = sample_words[word_index(s1, st)];
                if (step_voice(voices[1], s2, slot_len[s2], st))
                    f.audio2 = sample_words[word_index(s2, st)];
                expected_frames.push_back(f);
            end
            CMD_WRITE: begin
                if (it.slot < NUM_SLOTS) sample_words[word_index(it.slot, 16'(it.addr))] = it.data;
            end
            CMD_LENGTH: begin
                if (it.slot < NUM_SLOTS) slot_len[it.slot] = clamp_length(it.length);
            end
            default: ;
        endcase
    endfunction

    function automatic int random_note();
        return int'($urandom_range(0, NOTE_MAX - NOTE_MIN)) + NOTE_MIN;
    endfunction

    // a tick that would fetch a never-loaded word is turned into silence for that voice
    function automatic void keep_readable(inout logic signed [14:0] note, inout voice_t v);
        voice_t      trial;
        logic [2:0]  s;
        logic [15:0] st;
        int          mv;
        trial = v;
        s = match_slot(note);
        if (step_voice(trial, s, plan_len[s], st) && !word_written[word_index(s, st)]) begin
            mv = random_note();
            while (match_slot(mv) != NO_SLOT) mv = random_note();
            note = 15'(mv);
            trial = v;
            void'(step_voice(trial, NO_SLOT, '0, st));
        end
        v = trial;
    endfunction

    // queue one command; returns 1 unless the block simply ignores it
    function automatic bit plan_command(input cmd_item_t it);
        int s;
        s = int'(it.slot);
        case (it.command)
            CMD_TICK: begin
                keep_readable(it.note1, plan_voices[0]);
                keep_readable(it.note2, plan_voices[1]);
            end
            CMD_WRITE: begin
                if (s < NUM_SLOTS) begin
                    word_written[word_index(it.slot, 16'(it.addr))] = 1'b1;
                    while (written_prefix[s] < SLOT_DEPTH &&
                           word_written[word_index(it.slot, 16'(written_prefix[s]))])
                        written_prefix[s]++;
                end
            end
            CMD_LENGTH: begin
                if (s < NUM_SLOTS) plan_len[s] = clamp_length(it.length);
            end
            default: ;
        endcase
        pending_cmds.push_back(it);
        planned_count++;
        return (it.command == CMD_TICK) ||
               ((it.command != CMD_UNUSED) && (s < NUM_SLOTS));
    endfunction

    // every field random, so unused fields toggle too
    function automatic cmd_item_t junk_item(input logic [1:0] cmd);
        logic [95:0] raw;
        cmd_item_t   it;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(cmd_item_t)-1:0];
        it.command = cmd;
        return it;
    endfunction

    function automatic cmd_item_t make_tick(input int n1, input int n2);
        cmd_item_t it;
        it = junk_item(CMD_TICK);
        it.note1 = 15'(n1);
        it.note2 = 15'(n2);
        return it;
    endfunction

    function automatic cmd_item_t make_write(input int s, input int a, input logic [15:0] d);
        cmd_item_t it;
        it = junk_item(CMD_WRITE);
        it.slot = 3'(s);
        it.addr = 15'(a);
        it.data = d;
        return it;
    endfunction

    function automatic cmd_item_t make_length(input int s, input int len);
        cmd_item_t it;
        it = junk_item(CMD_LENGTH);
        it.slot = 3'(s);
        it.length = 16'(len);
        return it;
    endfunction

    // a voltage inside, on the edge of, or just outside the window of slot s, or a random one
    function automatic int aim_note(input int s);
        int c;
        int t;
        int mv;
        int r;
        if (s >= NUM_SLOTS) return random_note();
        c = int'(centers[s]);
        t = int'(tolerance);
        r = $urandom_range(0, 99);
        if (r < 60)      mv = c - t + int'($urandom_range(0, 2 * t));
        else if (r < 75) mv = $urandom_range(0, 1) ? c - t : c + t;
        else if (r < 88) mv = $urandom_range(0, 1) ? c - t - 1 : c + t + 1;
        else             mv = random_note();
        if (mv < NOTE_MIN) mv = NOTE_MIN;
        if (mv > NOTE_MAX) mv = NOTE_MAX;
        return mv;
    endfunction

    // gap length: mostly none, some short, a few long, with calm stretches
    function automatic int idle_len(inout bit calm);
        int r;
        if ($urandom_range(0, 99) == 0) calm = !calm;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic center_set_t random_centers(input int lo, input int hi);
        center_set_t c;
        for (int i = 0; i < NUM_SLOTS; i++) c[i] = 15'(int'($urandom_range(0, hi - lo)) + lo);
        return c;
    endfunction

    // register writes happen only with the block idle, so the predictor follows at once
    task automatic set_config(input center_set_t c, input logic [9:0] t);
        for (int i = 0; i <= NUM_SLOTS; i++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= (i == NUM_SLOTS) ? REG_TOLERANCE : REG_CENTER0 + 3'(i);
            i_cfg_data  <= (i == NUM_SLOTS) ? 15'(t) : c[i];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        centers   = c;
        tolerance = t;
    endtask

    // wait for every command to go in and every frame to come out, then let the pipe empty
    task automatic drain();
        while (accepted_count != planned_count || expected_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // short hand-written opening, reset windows 80..580 with tolerance 20
    task automatic directed_items();
        void'(plan_command(make_tick(0, NOTE_MIN)));            // both silent
        void'(plan_command(make_tick(NOTE_MAX, NOTE_MAX)));     // voltage extremes
        void'(plan_command(make_write(0, 0, 16'sh7FFF)));       // sample extremes
        void'(plan_command(make_write(0, 1, 16'sh8000)));
        void'(plan_command(make_write(0, 2, 16'sh1234)));
        void'(plan_command(make_write(6, 0, 16'hFFFF)));
        void'(plan_command(make_length(0, 3)));
        void'(plan_command(make_length(6, 1)));
        void'(plan_command(make_tick(80, 580)));                // both voices start
        void'(plan_command(make_tick(60, 600)));                // window edges, slot 6 ends
        void'(plan_command(make_tick(100, 601)));               // voice 2 falls out
        void'(plan_command(make_tick(80, 580)));                // past the end, retrigger
        void'(plan_command(make_tick(59, 170)));                // just outside, zero length
        void'(plan_command(junk_item(CMD_UNUSED)));             // unused command
        void'(plan_command(make_write(7, 5, 16'd999)));         // slot out of range
        void'(plan_command(make_length(7, 4)));
        void'(plan_command(make_write(3, 0, 16'sh7ABC)));
        void'(plan_command(make_write(3, SLOT_DEPTH - 1, 16'hFFFE)));  // top address
        void'(plan_command(make_length(3, 16'hFFFF)));          // too large, clamps
        void'(plan_command(make_tick(330, 350)));
        void'(plan_command(make_tick(330, 310)));
        void'(plan_command(make_length(3, SLOT_DEPTH)));        // same clamped length, then shrinks mid-play
        void'(plan_command(make_length(3, 0)));
        void'(plan_command(make_tick(330, 250)));
    endtask

    // load bursts, playing runs and some noise, until target counted commands are queued
    task automatic random_traffic(input int target);
        int made;
        int kind;
        int n;
        int s;
        int a;
        int r;
        int len;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                // load a run of words into a slot, then set its length
                s = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, NUM_SLOTS - 1);
                n = $urandom_range(1, 16);
                for (int k = 0; k < n; k++) begin
                    if (s < NUM_SLOTS && $urandom_range(0, 4) != 0 &&
                        written_prefix[s] < SLOT_DEPTH)
                        a = written_prefix[s];
                    else if ($urandom_range(0, 3) == 0)
                        a = SLOT_DEPTH - 1;
                    else
                        a = $urandom_range(0, SLOT_DEPTH - 1);
                    made += plan_command(make_write(s, a, 16'($urandom)));
                end
                r = $urandom_range(0, 99);
                if (s >= NUM_SLOTS)  len = $urandom_range(0, 65535);
                else if (r < 75)     len = $urandom_range(0, written_prefix[s]);
                else if (r < 90)     len = written_prefix[s] + $urandom_range(1, 8);
                else                 len = $urandom_range(SLOT_DEPTH, 65535);
                made += plan_command(make_length(s, len));
            end else if (kind < 90) begin
                // play: each voice holds a target slot and sometimes moves on
                n = $urandom_range(4, 40);
                for (int k = 0; k < n; k++) begin
                    for (int v = 0; v < 2; v++)
                        if ($urandom_range(0, 9) == 0) aim[v] = $urandom_range(0, NUM_SLOTS);
                    made += plan_command(make_tick(aim_note(aim[0]), aim_note(aim[1])));
                end
            end else begin
                r = $urandom_range(0, 3);
                if (r < 2)       void'(plan_command(junk_item(CMD_UNUSED)));
                else if (r == 2) void'(plan_command(make_write(7, $urandom_range(0, 32767),
                                                               16'($urandom))));
                else             void'(plan_command(make_length(7, $urandom_range(0, 65535))));
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // driver: a command goes out after its gap and stays until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                play_command(in_flight);
                accepted_count++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    in_flight = pending_cmds.pop_front();
                    in_if.command     <= in_flight.command;
                    in_if.note1_mv    <= in_flight.note1;
                    in_if.note2_mv    <= in_flight.note2;
                    in_if.load_slot   <= in_flight.slot;
                    in_if.load_addr   <= in_flight.addr;
                    in_if.load_data   <= in_flight.data;
                    in_if.slot_length <= in_flight.length;
                    in_if.valid       <= 1'b1;
                    send_gap = idle_len(calm_send);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: each frame transfer is checked against the oldest expected frame
    always @(posedge i_clk) begin
        frame_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t ns: unexpected frame, expected none, got %0d / %0d",
                             $time, out_if.audio1, out_if.audio2);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    if (out_if.audio1 !== want.audio1) begin
                        $display("%0t ns: audio1 expected %0d, got %0d",
                                 $time, want.audio1, out_if.audio1);
                        mismatches++;
                    end
                    if (out_if.audio2 !== want.audio2) begin
                        $display("%0t ns: audio2 expected %0d, got %0d",
                                 $time, want.audio2, out_if.audio2);
                        mismatches++;
                    end
                end
            end
            // stall the result side now and then
            if (hold_off > 0) begin
                hold_off--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                hold_off = idle_len(calm_recv);
            end
        end
    end

    // watchdog: too long without any transfer or register write means the block is stuck
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        // predictor and planner start from the reset state
        centers   = CENTER_RESET;
        tolerance = TOL_RESET;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_len[i]       = '0;
            plan_len[i]       = '0;
            written_prefix[i] = 0;
        end
        for (int v = 0; v < 2; v++) begin
            voices[v]      = '{step: '0, last: NO_SLOT};
            plan_voices[v] = '{step: '0, last: NO_SLOT};
        end
        aim[0] = 0;
        aim[1] = 1;
        planned_count  = 0;
        accepted_count = 0;
        mismatches     = 0;
        send_gap       = 0;
        hold_off       = 0;
        calm_send      = 1'b0;
        calm_recv      = 1'b0;
        idle_cycles    = 0;

        // every block input known from time zero
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        in_if.valid       = 1'b0;
        in_if.command     = CMD_TICK;
        in_if.note1_mv    = '0;
        in_if.note2_mv    = '0;
        in_if.load_slot   = '0;
        in_if.load_addr   = '0;
        in_if.load_data   = '0;
        in_if.slot_length = '0;
        out_if.ready      = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset windows
        directed_items();
        random_traffic(ITEMS_PER_PHASE);
        drain();

        // tolerance of 1000, extreme and overlapping centers, lowest slot must win
        set_config('{-15'sd10000, -15'sd9200, -15'sd9500, 15'sd0, 15'sd9990, 15'sd10000,
                     15'sd5000}, 10'd1000);
        random_traffic(ITEMS_PER_PHASE);
        drain();

        // zero tolerance, only exact voltages match
        set_config(random_centers(NOTE_MIN, NOTE_MAX), 10'd0);
        random_traffic(ITEMS_PER_PHASE);
        drain();

        // tight cluster of centers, windows overlap heavily
        set_config(random_centers(-300, 300), 10'($urandom_range(0, 200)));
        random_traffic(ITEMS_PER_PHASE);
        drain();

        // anything goes
        set_config(random_centers(NOTE_MIN, NOTE_MAX), 10'($urandom_range(0, 1000)));
        random_traffic(ITEMS_PER_PHASE);
        drain();

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/tvdsp_pkg.sv
design/tvdsp_in_if.sv
design/tvdsp_out_if.sv
design/tvdsp_front.sv
design/tvdsp_queue.sv
design/tvdsp_back.sv
design/two_voice_drum_sample_player.sv
test/two_voice_drum_sample_player_tb.sv
